>>> src/signed_fixed_point_cube_root_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cube root unit
// Clocked on clk and switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SIGNED_FIXED_POINT_CUBE_ROOT_UNIT_ASSERT_SVH
`define SIGNED_FIXED_POINT_CUBE_ROOT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBRT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cbrt_pkg.sv
// ---------------------------------------------------------------------------
// Cube root package
// Default widths and the control word carried along the pipeline.
// ---------------------------------------------------------------------------
package cbrt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ROOT_W         = 23;

    typedef struct packed {
        logic valid;
        logic neg;
    } ctrl_t;

endpackage

>>> src/signed_fixed_point_cube_root_unit.sv
// A radicand passes the input register, the bisection stages and the output register;
// ROOT_BITS = (DATA_WIDTH + 2*FRAC_BITS)/3 + 1 is the number of bisection stages.
// Throughput: one radicand per cycle; each root bit is one stage of a single add and compare.
// busy never rises, and results are never held off.
// Reset clears the valid bits of every stage; data registers are not reset.
// ---------------------------------------------------------------------------
// Signed fixed-point cube root unit
// Truncated cube root of the magnitude by pipelined bisection, one stage per
// root bit, with the sign of the radicand put back at the end.
// ---------------------------------------------------------------------------
`include "signed_fixed_point_cube_root_unit_assert.svh"

module signed_fixed_point_cube_root_unit #(
    parameter int DATA_WIDTH = cbrt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cbrt_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [DATA_WIDTH-1:0]        radicand,
    output logic                                done,
    output logic signed [cbrt_pkg::ROOT_W-1:0]  root
);
    import cbrt_pkg::*;

    localparam int ROOT_BITS = (DATA_WIDTH + 2 * FRAC_BITS) / 3 + 1;
    localparam int ACC_W     = 2 * ROOT_BITS + 4;
    localparam int LATENCY   = ROOT_BITS + 2;

    ctrl_t                 ctrl_s [0:ROOT_BITS];
    logic [DATA_WIDTH-1:0] mag_s  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0]  y_s    [0:ROOT_BITS];
    logic [ACC_W-1:0]      p_s    [0:ROOT_BITS];
    logic [ACC_W-1:0]      t_s    [0:ROOT_BITS];
    logic [ACC_W-1:0]      rem_s  [0:ROOT_BITS];

    assign busy = 1'b0;

    cbrt_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .radicand (radicand),
        .ctrl_out (ctrl_s[0]),
        .mag_out  (mag_s[0])
    );

    assign y_s[0]   = '0;
    assign p_s[0]   = '0;
    assign t_s[0]   = '0;
    assign rem_s[0] = '0;

    for (genvar i = 0; i < ROOT_BITS; i++)
    begin : g_step
        cbrt_step #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .ROOT_BITS  (ROOT_BITS),
            .ACC_W      (ACC_W),
            .STEP       (i)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_s[i]),
            .mag_in   (mag_s[i]),
            .y_in     (y_s[i]),
            .p_in     (p_s[i]),
            .t_in     (t_s[i]),
            .rem_in   (rem_s[i]),
            .ctrl_out (ctrl_s[i+1]),
            .mag_out  (mag_s[i+1]),
            .y_out    (y_s[i+1]),
            .p_out    (p_s[i+1]),
            .t_out    (t_s[i+1]),
            .rem_out  (rem_s[i+1])
        );
    end

    cbrt_back #(
        .ROOT_BITS (ROOT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (ctrl_s[ROOT_BITS]),
        .y_in    (y_s[ROOT_BITS]),
        .done    (done),
        .root    (root)
    );

    // Every accepted beat comes out on done, and nothing comes out
    // that was not accepted.
    `CBRT_ASSERT_SAME(a_start_gives_done, start && !busy, ##LATENCY done, "accepted beat lost")
    `CBRT_ASSERT_SAME(a_done_had_start, done, $past(start, LATENCY), "result without an input")
    `CBRT_ASSERT_SAME(a_zero_root, done && ($past(radicand, LATENCY) == '0), root == '0, "nonzero root of zero")

endmodule

>>> src/cbrt_front.sv
// ---------------------------------------------------------------------------
// Cube root input stage
// Registers the sign of the radicand and its magnitude.
// ---------------------------------------------------------------------------
module cbrt_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] radicand,
    output cbrt_pkg::ctrl_t       ctrl_out,
    output logic [DATA_WIDTH-1:0] mag_out
);
    import cbrt_pkg::*;

    ctrl_t                 ctrl_reg;
    ctrl_t                 ctrl_next;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic [DATA_WIDTH-1:0] mag_next;

    // The most negative value negates to itself, which read unsigned is
    // exactly its magnitude.
    always_comb
    begin
        ctrl_next.valid = start;
        ctrl_next.neg   = radicand[DATA_WIDTH-1];
        mag_next        = radicand[DATA_WIDTH-1] ? (~radicand + 1'b1) : radicand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

    assign ctrl_out = ctrl_reg;
    assign mag_out  = mag_reg;

endmodule

>>> src/cbrt_step.sv
// ---------------------------------------------------------------------------
// Cube root bisection stage
// Decides one root bit from the next three radicand bits, without multipliers.
// ---------------------------------------------------------------------------
module cbrt_step #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int ROOT_BITS  = 22,
    parameter int ACC_W      = 48,
    parameter int STEP       = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbrt_pkg::ctrl_t       ctrl_in,
    input  logic [DATA_WIDTH-1:0] mag_in,
    input  logic [ROOT_BITS-1:0]  y_in,
    input  logic [ACC_W-1:0]      p_in,
    input  logic [ACC_W-1:0]      t_in,
    input  logic [ACC_W-1:0]      rem_in,
    output cbrt_pkg::ctrl_t       ctrl_out,
    output logic [DATA_WIDTH-1:0] mag_out,
    output logic [ROOT_BITS-1:0]  y_out,
    output logic [ACC_W-1:0]      p_out,
    output logic [ACC_W-1:0]      t_out,
    output logic [ACC_W-1:0]      rem_out
);
    import cbrt_pkg::*;

    localparam int TW      = 3 * ROOT_BITS;
    localparam int GRP_LSB = 3 * (ROOT_BITS - 1 - STEP);

    ctrl_t                 ctrl_reg;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic [ROOT_BITS-1:0]  y_reg;
    logic [ROOT_BITS-1:0]  y_next;
    logic [ACC_W-1:0]      p_reg;
    logic [ACC_W-1:0]      p_next;
    logic [ACC_W-1:0]      t_reg;
    logic [ACC_W-1:0]      t_next;
    logic [ACC_W-1:0]      rem_reg;
    logic [ACC_W-1:0]      rem_next;

    logic [TW-1:0]         target;
    logic [2:0]            grp;
    logic [ACC_W-1:0]      rem_sh;
    logic [ACC_W-1:0]      trial;
    logic [ACC_W-1:0]      p_take;
    logic                  take;

    // p holds 3*y*y and t holds 3*y for the partial root y, so the trial
    // value 3*(2y)^2 + 3*(2y) + 1 is a single add.
    always_comb
    begin
        target   = TW'(mag_in) << (2 * FRAC_BITS);
        grp      = target[GRP_LSB +: 3];
        rem_sh   = {rem_in[ACC_W-4:0], grp};
        trial    = (p_in << 2) + (t_in << 1) + ACC_W'(1);
        p_take   = (p_in << 2) + (t_in << 2) + ACC_W'(3);
        take     = (rem_sh >= trial);
        rem_next = take ? (rem_sh - trial) : rem_sh;
        y_next   = {y_in[ROOT_BITS-2:0], take};
        p_next   = take ? p_take : (p_in << 2);
        t_next   = take ? ((t_in << 1) + ACC_W'(3)) : (t_in << 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_in;
        y_reg   <= y_next;
        p_reg   <= p_next;
        t_reg   <= t_next;
        rem_reg <= rem_next;
    end

    assign ctrl_out = ctrl_reg;
    assign mag_out  = mag_reg;
    assign y_out    = y_reg;
    assign p_out    = p_reg;
    assign t_out    = t_reg;
    assign rem_out  = rem_reg;

endmodule

>>> src/cbrt_back.sv
// ---------------------------------------------------------------------------
// Cube root output stage
// Restores the sign of the radicand and presents the result beat.
// ---------------------------------------------------------------------------
module cbrt_back #(
    parameter int ROOT_BITS = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbrt_pkg::ctrl_t               ctrl_in,
    input  logic [ROOT_BITS-1:0]          y_in,
    output logic                          done,
    output logic [cbrt_pkg::ROOT_W-1:0]   root
);
    import cbrt_pkg::*;

    logic              done_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [ROOT_W-1:0] mag_w;

    // Negating after the size cast gives the same low bits as negating first.
    always_comb
    begin
        mag_w     = ROOT_W'(y_in);
        root_next = ctrl_in.neg ? (ROOT_W'(0) - mag_w) : mag_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
